// ===== src/lus_pkg.sv =====
`timescale 1ns / 1ps

package lus_pkg;

  // Largest package size the reach window can serve.
  localparam int MAX_SIZE   = 255;
  // Width of the amount counter; limits are taken modulo 2**LIMIT_BITS.
  localparam int LIMIT_BITS = 16;

  localparam int SIZE_W    = 8;
  localparam int FIELD_W   = 16;
  localparam int CFG_IDX_W = 8;
  localparam int WIN_IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIZE_A = 8'd0,
    REG_SIZE_B = 8'd1,
    REG_SIZE_C = 8'd2,
    REG_SIZE_D = 8'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  typedef struct packed {
    logic clr;
    logic shift;
  } cell_ctrl_t;

endpackage

// ===== src/lus_cell.sv =====
`timescale 1ns / 1ps

module lus_cell (
  input  logic               clk,
  input  lus_pkg::cell_ctrl_t ctrl,
  input  logic               din,
  output logic               q
);
  import lus_pkg::*;

  // One reach bit of the window; it takes its neighbor's bit on every shift.
  always_ff @(posedge clk) begin
    if (ctrl.clr) begin
      q <= 1'b0;
    end else if (ctrl.shift) begin
      q <= din;
    end
  end

endmodule

// ===== src/largest_unreachable_sum.sv =====
`timescale 1ns / 1ps

// Finds the largest amount from 0 to limit that no non-negative combination of
// the four package sizes adds up to. An item is accepted when start is high and
// busy is low; the block then checks one amount per cycle through a chain of
// reach-bit cells while busy stays high. The result is shown for exactly one
// cycle with done high and must be captured then. Busy drops in that same
// cycle, so the next item can be accepted while the result is on the ports.
// When every amount up to limit is formable, none_unreachable is 1 and
// largest_unreachable is 0. The user must write sizes on the config port only
// while the block is idle; the block itself does not enforce it. A size of
// zero is ignored, and writes to indexes above three have no effect.
module largest_unreachable_sum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lus_pkg::FIELD_W-1:0]   limit,
  output logic                          done,
  output logic [lus_pkg::FIELD_W-1:0]   largest_unreachable,
  output logic                          none_unreachable,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lus_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lus_pkg::SIZE_W-1:0]    cfg_data
);
  import lus_pkg::*;

  logic [SIZE_W-1:0]     size_a;
  logic [SIZE_W-1:0]     size_b;
  logic [SIZE_W-1:0]     size_c;
  logic [SIZE_W-1:0]     size_d;
  state_t                state;
  logic [LIMIT_BITS-1:0] limit_q;
  logic [LIMIT_BITS-1:0] amount_counter;
  logic [LIMIT_BITS-1:0] last_gap;
  logic                  gap_found;

  logic                  accept;
  logic                  running;
  logic                  last_amount;
  logic                  reach;
  logic [LIMIT_BITS-1:0] gap_next;
  logic                  found_next;
  logic [MAX_SIZE-1:0]   win;
  cell_ctrl_t            cell_ctrl;

  assign cfg_ready   = 1'b1;
  assign busy        = (state == ST_RUN);
  assign accept      = start && !busy;
  assign running     = (state == ST_RUN);
  assign last_amount = (amount_counter == limit_q);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_a <= SIZE_W'(1);
      size_b <= SIZE_W'(1);
      size_c <= SIZE_W'(1);
      size_d <= SIZE_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SIZE_A: size_a <= cfg_data;
        REG_SIZE_B: size_b <= cfg_data;
        REG_SIZE_C: size_c <= cfg_data;
        REG_SIZE_D: size_d <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cell i holds the reach bit of amount minus (i + 1), so a size s taps cell
  // s - 1. Cells are cleared when an item starts, which makes sizes larger than
  // the current amount read as unreached.
  function automatic logic tap(input logic [MAX_SIZE-1:0] w, input logic [SIZE_W-1:0] s);
    logic [WIN_IDX_W-1:0] idx;
    logic                 usable;
    idx    = WIN_IDX_W'(32'(s) - 32'd1);
    usable = (s != '0) && (32'(s) <= MAX_SIZE);
    return usable && w[idx];
  endfunction

  assign reach = (amount_counter == '0) || tap(win, size_a) || tap(win, size_b)
              || tap(win, size_c) || tap(win, size_d);

  assign cell_ctrl.clr   = rst || accept;
  assign cell_ctrl.shift = running;

  for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
    lus_cell u_cell (
      .clk  (clk),
      .ctrl (cell_ctrl),
      .din  ((i == 0) ? reach : win[(i == 0) ? 0 : i - 1]),
      .q    (win[i])
    );
  end

  always_comb begin
    gap_next   = last_gap;
    found_next = gap_found;
    if (!reach) begin
      gap_next   = amount_counter;
      found_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      done           <= 1'b0;
      amount_counter <= '0;
      last_gap       <= '0;
      gap_found      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            state          <= ST_RUN;
            amount_counter <= '0;
            last_gap       <= '0;
            gap_found      <= 1'b0;
          end
        end
        ST_RUN: begin
          last_gap  <= gap_next;
          gap_found <= found_next;
          if (last_amount) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            amount_counter <= amount_counter + 1'b1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      limit_q <= LIMIT_BITS'(limit);
    end
    if (running && last_amount) begin
      largest_unreachable <= found_next ? FIELD_W'(gap_next) : '0;
      none_unreachable    <= !found_next;
    end
  end

endmodule

// ===== tb/sv/largest_unreachable_sum_test.sv =====
`timescale 1ns / 1ps

module largest_unreachable_sum_test;
  import lus_pkg::*;

  localparam int WINDOW          = MAX_SIZE + 1;
  localparam int WATCHDOG_CYCLES = 300000;

  typedef struct packed {
    logic [FIELD_W-1:0] gap;
    logic               none;
  } gap_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [FIELD_W-1:0]   limit = '0;
  logic                 done;
  logic [FIELD_W-1:0]   largest_unreachable;
  logic                 none_unreachable;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [SIZE_W-1:0]    cfg_data = '0;

  // Limits waiting to be driven, and results predicted for accepted limits.
  logic [FIELD_W-1:0] limit_queue[$];
  gap_result_t        expected_gaps[$];

  // Our copy of the four package sizes.
  logic [SIZE_W-1:0] pkg_size[4];

  logic limit_taken = 1'b0;
  int   send_idle_pct = 0;
  int   fail_count = 0;
  int   items_sent = 0;
  int   results_seen = 0;
  int   size_writes = 0;
  int   idle_cycles = 0;
  int   last_limit = 0;
  int   phase_count = 0;

  largest_unreachable_sum DUT (
    .clk                 (clk),
    .rst                 (rst),
    .start               (start),
    .busy                (busy),
    .limit               (limit),
    .done                (done),
    .largest_unreachable (largest_unreachable),
    .none_unreachable    (none_unreachable),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Walks every amount up to the limit with a rolling window of reach bits.
  function automatic gap_result_t find_largest_gap(input logic [FIELD_W-1:0] upto,
                                                   input logic [SIZE_W-1:0] sizes[4]);
    bit          reach[WINDOW];
    bit          hit;
    gap_result_t res;
    res.gap  = '0;
    res.none = 1'b1;
    foreach (reach[i]) reach[i] = 1'b0;
    for (int x = 0; x <= int'(upto); x++) begin
      hit = (x == 0);
      foreach (sizes[k]) begin
        // Zero sizes form nothing but zero, so they never add reach.
        if (sizes[k] != 0 && sizes[k] <= MAX_SIZE && int'(sizes[k]) <= x &&
            reach[(x - int'(sizes[k])) % WINDOW])
          hit = 1'b1;
      end
      reach[x % WINDOW] = hit;
      if (!hit) begin
        res.gap  = FIELD_W'(x);
        res.none = 1'b0;
      end
    end
    return res;
  endfunction

  always @(negedge clk) begin : drive_limits
    logic               go;
    logic [FIELD_W-1:0] next_limit;
    go         = start && !limit_taken;
    next_limit = limit;
    if (!rst && !go && limit_queue.size() != 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      go         = 1'b1;
      next_limit = limit_queue.pop_front();
    end
    if (rst)
      go = 1'b0;
    start <= go;
    limit <= next_limit;
  end

  always @(posedge clk) begin : watch_ports
    gap_result_t want;
    if (rst) begin
      limit_taken <= 1'b0;
      foreach (pkg_size[i]) pkg_size[i] <= 8'd1;
      idle_cycles = 0;
    end else begin
      limit_taken <= start && !busy;
      if (start && !busy) begin
        expected_gaps.insert(expected_gaps.size(), find_largest_gap(limit, pkg_size));
        items_sent++;
        last_limit = int'(limit);
      end
      if (cfg_valid && cfg_ready) begin
        size_writes++;
        case (cfg_index)
          REG_SIZE_A: pkg_size[0] <= cfg_data;
          REG_SIZE_B: pkg_size[1] <= cfg_data;
          REG_SIZE_C: pkg_size[2] <= cfg_data;
          REG_SIZE_D: pkg_size[3] <= cfg_data;
          default: ;
        endcase
      end
      if (done) begin
        results_seen++;
        if (expected_gaps.size() == 0) begin
          $display("%0t: unexpected result largest_unreachable=%0d none_unreachable=%0b",
                   $time, largest_unreachable, none_unreachable);
          fail_count++;
        end else begin
          want = expected_gaps.pop_front();
          if (largest_unreachable !== want.gap) begin
            $display("%0t: largest_unreachable expected %0d, got %0d",
                     $time, want.gap, largest_unreachable);
            fail_count++;
          end
          if (none_unreachable !== want.none) begin
            $display("%0t: none_unreachable expected %0b, got %0b",
                     $time, want.none, none_unreachable);
            fail_count++;
          end
        end
      end
      if ((start && !busy) || done || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t: no beat for %0d cycles", $time, idle_cycles);
        $display("** largest_unreachable_sum: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_size(input logic [CFG_IDX_W-1:0] index, input logic [SIZE_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_sizes(input logic [SIZE_W-1:0] a, input logic [SIZE_W-1:0] b,
                           input logic [SIZE_W-1:0] c, input logic [SIZE_W-1:0] d);
    write_size(REG_SIZE_A, a);
    write_size(REG_SIZE_B, b);
    write_size(REG_SIZE_C, c);
    write_size(REG_SIZE_D, d);
  endtask

  // The sender holds off here until every predicted result has come back.
  task automatic wait_drained();
    @(posedge clk);
    while (limit_queue.size() != 0 || start || expected_gaps.size() != 0) @(posedge clk);
    phase_count++;
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    if ($urandom_range(0, 3) == 0)
      return SIZE_W'($urandom_range(1, 255));
    return SIZE_W'($urandom_range(1, 24));
  endfunction

  function automatic logic [FIELD_W-1:0] pick_limit();
    int r;
    r = $urandom_range(0, 39);
    if (r == 0)
      return FIELD_W'($urandom_range(0, 65535));
    if (r < 6)
      return FIELD_W'($urandom_range(0, 4000));
    return FIELD_W'($urandom_range(0, 500));
  endfunction

  initial begin
    int idle_plan[4];
    idle_plan = '{0, 74, 34, 0};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Sizes straight out of reset are all one, so every amount is formable.
    limit_queue = '{16'd0, 16'd3};
    wait_drained();

    set_sizes(8'd6, 8'd9, 8'd20, 8'd20);
    send_idle_pct = 74;
    limit_queue = '{16'd0, 16'd1, 16'd42, 16'd43, 16'd44, 16'd200, 16'hFFFF};
    wait_drained();

    // Largest sizes, plus a write to an index with no register behind it.
    set_sizes(8'd255, 8'd255, 8'd255, 8'd255);
    write_size(CFG_IDX_W'($urandom_range(int'(REG_SIZE_D) + 1, 255)),
               SIZE_W'($urandom_range(0, 255)));
    send_idle_pct = 0;
    limit_queue = '{16'd254, 16'd255, 16'd256, 16'hFFFF};
    wait_drained();

    // Zero sizes drop out; only 7 and 11 remain.
    set_sizes(8'd0, 8'd7, 8'd0, 8'd11);
    limit_queue = '{16'd1, 16'd59, 16'd100};
    wait_drained();

    set_sizes(8'd2, 8'd4, 8'd6, 8'd8);
    limit_queue = '{16'd1000};
    wait_drained();

    foreach (idle_plan[p]) begin
      set_sizes(pick_size(), pick_size(), pick_size(), pick_size());
      if ($urandom_range(0, 1) == 0)
        write_size(CFG_IDX_W'($urandom_range(int'(REG_SIZE_D) + 1, 255)),
                   SIZE_W'($urandom_range(0, 255)));
      send_idle_pct = idle_plan[p];
      repeat (21) limit_queue.insert(limit_queue.size(), pick_limit());
      wait_drained();
    end

    repeat (last_limit + 8) @(posedge clk);

    foreach (expected_gaps[i]) begin
      $display("%0t: result never arrived: expected largest_unreachable=%0d none_unreachable=%0b",
               $time, expected_gaps[i].gap, expected_gaps[i].none);
      fail_count++;
    end
    $display("Ran %0d limits through %0d size settings (%0d register writes).",
             items_sent, phase_count, size_writes);
    $display("Checked %0d results, %0d mismatches.", results_seen, fail_count);
    if (fail_count == 0) begin
      $display("** largest_unreachable_sum: PASSED **");
    end else begin
      $display("** largest_unreachable_sum: FAILED **");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/lus_pkg.sv
src/lus_cell.sv
src/largest_unreachable_sum.sv
tb/sv/largest_unreachable_sum_test.sv
